FILE: rtl/cmksc_pkg.sv
// Shared types and constants for the card MAC key search check.
`timescale 1ns / 1ps

package cmksc_pkg;

    localparam int IndexWidth    = 40;
    localparam int KeyWidth      = 64;
    localparam int CfgDataWidth  = 64;
    localparam int CfgAddrWidth  = 2;
    localparam int InDataWidth   = 40;   // key_index, already whole bytes
    localparam int OutDataWidth  = 48;   // match + tried_index, padded to bytes
    localparam int ChalBits      = 96;
    localparam int MacBits       = 32;
    localparam int CountWidth    = 7;

    localparam logic [CountWidth-1:0] AbsorbRounds = 7'd96;
    localparam logic [CountWidth-1:0] LastCount    = 7'd127;

    // cipher init constants
    localparam logic [7:0]  KeyXorInit = 8'h4C;
    localparam logic [7:0]  LeftAdd    = 8'hEC;
    localparam logic [7:0]  RightAdd   = 8'h21;
    localparam logic [7:0]  FbInit     = 8'h4C;
    localparam logic [15:0] TopInit    = 16'hE012;

    // configuration register indexes
    localparam logic [CfgAddrWidth-1:0] RegFixedKeyBits = 2'd0;
    localparam logic [CfgAddrWidth-1:0] RegChalLow      = 2'd1;
    localparam logic [CfgAddrWidth-1:0] RegChalHigh     = 2'd2;
    localparam logic [CfgAddrWidth-1:0] RegTargetMac    = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

endpackage

FILE: rtl/card_mac_key_search_check.sv
// Top level: one candidate key tested against the target MAC, one cipher round a cycle.
`timescale 1ns / 1ps

// Channel   Dir  Payload (lowest bit up)              Handshake
// s         in   tdata[39:0] key_index                 i_s_tvalid / o_s_tready
// m         out  tdata[0] match, [40:1] tried_index    o_m_tvalid / i_m_tready
// cfg       in   i_cfg_addr register, i_cfg_data value i_cfg_we (no wait)
//
// Sequence: an item is taken in IDLE (key built, cipher state loaded), then
// the shared round unit runs 127 rounds, with the last 32 states compared
// one bit each against the target MAC. The single round unit (8-bit key
// select plus two chained 8-bit adds) serves every round. Reset is
// synchronous, active low, and leaves the block idle.
// A result waits in the output register; a new item is taken meanwhile. The
// round loop holds its last step only if the previous result is still unread.

module card_mac_key_search_check (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // stream in
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    input  logic [cmksc_pkg::InDataWidth-1:0]      i_s_tdata,   // [39:0] key_index
    // stream out
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    output logic [cmksc_pkg::OutDataWidth-1:0]     o_m_tdata,   // [0] match, [40:1] tried_index
    // configuration writes
    input  logic                                   i_cfg_we,
    input  logic [cmksc_pkg::CfgAddrWidth-1:0]     i_cfg_addr,
    input  logic [cmksc_pkg::CfgDataWidth-1:0]     i_cfg_data
);
    import cmksc_pkg::*;

    // configuration
    logic [23:0]          r_fixed_bits;
    logic [ChalBits-1:0]  r_chal;
    logic [MacBits-1:0]   r_target;

    // sequencer and cipher state
    t_state               r_state, n_state;
    logic [CountWidth-1:0] r_cnt, n_cnt;
    logic [7:0]           r_l, n_l;
    logic [7:0]           r_r, n_r;
    logic [7:0]           r_b, n_b;
    logic [15:0]          r_t, n_t;
    logic [KeyWidth-1:0]  r_key, n_key;
    logic [IndexWidth-1:0] r_idx, n_idx;
    logic                 r_ok, n_ok;

    // output register
    logic                 r_out_valid, n_out_valid;
    logic                 r_out_match, n_out_match;
    logic [IndexWidth-1:0] r_out_idx, n_out_idx;

    logic s_accept;
    logic finish;
    logic cmp_phase;
    logic do_round;

    // round unit signals
    logic       tt, bt, y;
    logic [7:0] c;
    logic       z0, z1, z2;
    logic [2:0] sel;
    logic [7:0] rnd_b, rnd_val, rnd_r, rnd_l;
    logic [15:0] rnd_t;
    logic [KeyWidth-1:0] new_key;
    logic [7:0] k0x;

    assign o_s_tready = (r_state == ST_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign cmp_phase  = (r_cnt >= AbsorbRounds);
    assign do_round   = (r_cnt != LastCount);
    assign finish     = (r_state == ST_RUN) && !do_round && (!r_out_valid || i_m_tready);

    // key byte j: fixed bits 3j+2..3j low, index bits 5(7-j)+4..5(7-j) high
    always_comb begin
        for (int j = 0; j < 8; j++) begin
            new_key[8*j +: 3]     = r_fixed_bits[3*j +: 3];
            new_key[8*j + 3 +: 5] = i_s_tdata[5*(7-j) +: 5];
        end
    end
    assign k0x = new_key[7:0] ^ KeyXorInit;

    // shared cipher round
    always_comb begin
        c     = {r_r[0], r_r[1], r_r[2], r_r[3], r_r[4], r_r[5], r_r[6], r_r[7]};
        y     = cmp_phase ? 1'b0 : r_chal[r_cnt];
        tt    = r_t[15] ^ r_t[14] ^ r_t[10] ^ r_t[8] ^ r_t[5] ^ r_t[4] ^ r_t[1] ^ r_t[0];
        bt    = r_b[6] ^ r_b[5] ^ r_b[4] ^ r_b[0];
        rnd_t = {tt ^ c[0] ^ c[4], r_t[15:1]};
        rnd_b = {bt ^ c[7], r_b[7:1]};
        z0    = (c[0] & c[2]) ^ (c[1] & ~c[3]) ^ (c[2] | c[4]);
        z1    = (c[0] | c[2]) ^ (c[5] | c[7]) ^ c[1] ^ c[6] ^ tt ^ y;
        z2    = (c[3] & ~c[5]) ^ (c[4] & c[6]) ^ c[7] ^ tt;
        sel   = {z0, z1, z2};
        rnd_val = r_key[8*sel +: 8] ^ rnd_b;
        rnd_r = rnd_val + r_l;
        rnd_l = rnd_r + r_r;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_l         = r_l;
        n_r         = r_r;
        n_b         = r_b;
        n_t         = r_t;
        n_key       = r_key;
        n_idx       = r_idx;
        n_ok        = r_ok;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_match = r_out_match;
        n_out_idx   = r_out_idx;

        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_key   = new_key;
                    n_idx   = i_s_tdata[IndexWidth-1:0];
                    n_l     = k0x + LeftAdd;
                    n_r     = k0x + RightAdd;
                    n_b     = FbInit;
                    n_t     = TopInit;
                    n_cnt   = '0;
                    n_ok    = 1'b1;
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                // MAC bit n sits in r[2] after 96+n rounds
                if (cmp_phase) begin
                    n_ok = r_ok && (r_r[2] == r_target[r_cnt[4:0]]);
                end
                if (do_round) begin
                    n_t   = rnd_t;
                    n_b   = rnd_b;
                    n_r   = rnd_r;
                    n_l   = rnd_l;
                    n_cnt = r_cnt + 1'b1;
                end
                if (finish) begin
                    n_out_valid = 1'b1;
                    n_out_match = n_ok;
                    n_out_idx   = r_idx;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_ok        <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_ok        <= n_ok;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_l         <= n_l;
        r_r         <= n_r;
        r_b         <= n_b;
        r_t         <= n_t;
        r_key       <= n_key;
        r_idx       <= n_idx;
        r_out_match <= n_out_match;
        r_out_idx   <= n_out_idx;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fixed_bits <= '0;
            r_chal       <= '0;
            r_target     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                RegFixedKeyBits: r_fixed_bits   <= i_cfg_data[23:0];
                RegChalLow:      r_chal[63:0]   <= i_cfg_data;
                RegChalHigh:     r_chal[95:64]  <= i_cfg_data[31:0];
                RegTargetMac:    r_target       <= i_cfg_data[MacBits-1:0];
                default: ;
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OutDataWidth-IndexWidth-1){1'b0}}, r_out_idx, r_out_match};

    // an accepted item starts the round loop from zero
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_state == ST_RUN) && (r_cnt == '0) && r_ok)
        else $error("round loop not started on accept");

    // rounds advance one per cycle until the last count
    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) && do_round |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("round counter skipped");

    // a mismatch can only be found during the compare rounds
    a_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_ok) |-> ($past(r_cnt) >= AbsorbRounds))
        else $error("mismatch flagged during absorb");

    // a result is written only when the slot is free or being drained
    a_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |-> (!r_out_valid || i_m_tready))
        else $error("result overwrote a pending one");

endmodule
